/* design/ts_sched_pkg.sv */
// Shared types, constants and helpers for the transport-stream slot scheduler.
`default_nettype none
package ts_sched_pkg;

	localparam int ENTRIES   = 64;
	localparam int FRAC_BITS = 8;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int SPP_W  = 16;
	localparam int SID_W  = 13;
	localparam int IV_W   = 24;
	localparam int DUE_W  = 32;
	localparam int ACC_W  = DUE_W + 2;
	localparam int POS_FW = SPP_W + FRAC_BITS;
	localparam int LIV_W  = IV_W + 4;

	localparam logic [SPP_W-1:0] SPP_RESET = SPP_W'(1000);
	localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(ENTRIES);
	localparam logic [LIV_W-1:0] FAST_LIM  = LIV_W'(1) << FRAC_BITS;

	localparam logic signed [DUE_W-1:0] DUE_MAX = {1'b0, {(DUE_W-1){1'b1}}};
	localparam logic signed [DUE_W-1:0] DUE_MIN = {1'b1, {(DUE_W-1){1'b0}}};

	localparam logic [1:0] KIND_NULL = 2'd0;
	localparam logic [1:0] KIND_REAL = 2'd1;
	localparam logic [1:0] KIND_LOAD = 2'd2;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_SLOT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_REBASE
	} state_t;

	typedef struct packed {
		logic                    live;
		logic [SID_W-1:0]        sid;
		logic [IV_W-1:0]         iv;
		logic signed [DUE_W-1:0] due;
	} entry_t;

	localparam int WORD_W = $bits(entry_t);

	function automatic logic is_live(input logic [SID_W-1:0] sid, input logic [IV_W-1:0] iv);
		logic [LIV_W-1:0] x10;
		x10 = {1'b0, iv, 3'b000} + {3'b000, iv, 1'b0};
		return (sid != '0) && (x10 > FAST_LIM);
	endfunction

	function automatic logic signed [DUE_W-1:0] sat_due(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-DUE_W:0] top;
		top = v[ACC_W-1:DUE_W-1];
		if ((&top) || !(|top)) begin
			return v[DUE_W-1:0];
		end else if (v[ACC_W-1]) begin
			return DUE_MIN;
		end
		return DUE_MAX;
	endfunction

endpackage
`default_nettype wire

/* design/ts_sched_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ts_sched_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [DATA_W-1:0]          wr_data,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output      logic [DATA_W-1:0]          rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* design/ts_sched_alu.sv */
// Shared adder with due-position saturation, used by scan, advance and rebase.
`default_nettype none
module ts_sched_alu (
	input  wire logic signed [ts_sched_pkg::ACC_W-1:0] a,
	input  wire logic signed [ts_sched_pkg::ACC_W-1:0] b,
	output      logic signed [ts_sched_pkg::ACC_W-1:0] sum,
	output      logic signed [ts_sched_pkg::DUE_W-1:0] sat
);

	assign sum = a + b;
	assign sat = ts_sched_pkg::sat_due(sum);

endmodule
`default_nettype wire

/* design/ts_slot_most_overdue_scheduler.sv */
// Top level of the transport-stream slot scheduler: sequencer, entry table and result port.
`default_nettype none
// A load item (func 0) writes one table entry in the cycle it is accepted and reports
// done in the cycle after. A slot item (func 1) scans the table one entry per cycle through
// a single RAM read port and one shared adder, and a slot that closes the period adds
// a rebase pass that walks the table again through the same port. busy stays high for
// that whole time. Each result appears for exactly one cycle with done high and cannot
// be held off by the receiver.
module ts_slot_most_overdue_scheduler (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output      logic                              busy,
	input  wire logic                              func,
	input  wire logic [5:0]                        entry_index,
	input  wire logic [ts_sched_pkg::SID_W-1:0]    stream_id,
	input  wire logic [ts_sched_pkg::IV_W-1:0]     interval,
	input  wire logic                              cfg_we,
	input  wire logic [ts_sched_pkg::SPP_W-1:0]    cfg_wdata,
	output      logic                              done,
	output      logic [1:0]                        slot_kind,
	output      logic [5:0]                        chosen_index,
	output      logic [ts_sched_pkg::SID_W-1:0]    chosen_stream,
	output      logic                              period_end
);

	ts_sched_pkg::state_t state_q, state_d;

	logic [ts_sched_pkg::CNT_W-1:0]        cnt_q;
	logic                                  rd_vld_s1;
	logic                                  valid_s1;
	logic [ts_sched_pkg::IDX_W-1:0]        idx_s1;
	logic [ts_sched_pkg::ENTRIES-1:0]      valid_q;
	logic [ts_sched_pkg::SPP_W-1:0]        spp_q;
	logic [ts_sched_pkg::SPP_W-1:0]        pos_q;
	logic                                  closing_q;
	logic                                  found_q;
	logic signed [ts_sched_pkg::ACC_W-1:0] best_q;
	logic [ts_sched_pkg::IDX_W-1:0]        pick_q;
	ts_sched_pkg::entry_t                  pick_q_ent;

	logic                                  done_q;
	logic [1:0]                            slot_kind_q;
	logic [5:0]                            chosen_index_q;
	logic [ts_sched_pkg::SID_W-1:0]        chosen_stream_q;
	logic                                  period_end_q;

	logic                                  accept;
	logic                                  load_ok;
	logic                                  issue;
	logic                                  pass_done;
	logic                                  emit;
	logic                                  better;
	logic                                  live_s1;
	logic [ts_sched_pkg::IDX_W-1:0]        rd_addr;
	logic [ts_sched_pkg::WORD_W-1:0]       rd_data;
	ts_sched_pkg::entry_t                  rd_ent;
	logic                                  wr_en;
	logic [ts_sched_pkg::IDX_W-1:0]        wr_addr;
	ts_sched_pkg::entry_t                  wr_ent;
	logic signed [ts_sched_pkg::ACC_W-1:0] alu_a;
	logic signed [ts_sched_pkg::ACC_W-1:0] alu_b;
	logic signed [ts_sched_pkg::ACC_W-1:0] alu_sum;
	logic signed [ts_sched_pkg::DUE_W-1:0] alu_sat;
	logic signed [ts_sched_pkg::ACC_W-1:0] rd_due_x;
	logic signed [ts_sched_pkg::ACC_W-1:0] pick_due_x;
	logic signed [ts_sched_pkg::ACC_W-1:0] pos_x;
	logic signed [ts_sched_pkg::ACC_W-1:0] shift_x;

	assign busy      = (state_q != ts_sched_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign load_ok   = int'(entry_index) < ts_sched_pkg::ENTRIES;
	assign rd_addr   = cnt_q[ts_sched_pkg::IDX_W-1:0];
	assign rd_ent    = ts_sched_pkg::entry_t'(rd_data);
	assign live_s1   = rd_vld_s1 && valid_s1 && rd_ent.live;
	assign pass_done = (cnt_q == ts_sched_pkg::CNT_END) && !rd_vld_s1;
	assign better    = live_s1 && (alu_sum > best_q);

	assign rd_due_x   = {{(ts_sched_pkg::ACC_W-ts_sched_pkg::DUE_W){rd_ent.due[ts_sched_pkg::DUE_W-1]}},
		rd_ent.due};
	assign pick_due_x = {{(ts_sched_pkg::ACC_W-ts_sched_pkg::DUE_W){pick_q_ent.due[ts_sched_pkg::DUE_W-1]}},
		pick_q_ent.due};
	assign pos_x      = {{(ts_sched_pkg::ACC_W-ts_sched_pkg::POS_FW){1'b0}}, pos_q,
		{ts_sched_pkg::FRAC_BITS{1'b0}}};
	assign shift_x    = {{(ts_sched_pkg::ACC_W-ts_sched_pkg::POS_FW){1'b0}}, spp_q,
		{ts_sched_pkg::FRAC_BITS{1'b0}}};

	ts_sched_ram #(
		.DATA_W(ts_sched_pkg::WORD_W),
		.DEPTH (ts_sched_pkg::ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_ent),
		.rd_en  (issue),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	ts_sched_alu u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.sum(alu_sum),
		.sat(alu_sat)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ts_sched_pkg::ST_IDLE: begin
				if (accept && func == ts_sched_pkg::FUNC_SLOT) begin
					state_d = ts_sched_pkg::ST_SCAN;
				end
			end
			ts_sched_pkg::ST_SCAN: begin
				if (pass_done) begin
					state_d = ts_sched_pkg::ST_UPDATE;
				end
			end
			ts_sched_pkg::ST_UPDATE: begin
				state_d = closing_q ? ts_sched_pkg::ST_REBASE : ts_sched_pkg::ST_IDLE;
			end
			ts_sched_pkg::ST_REBASE: begin
				if (pass_done) begin
					state_d = ts_sched_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ts_sched_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		issue   = 1'b0;
		emit    = 1'b0;
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_ent  = rd_ent;
		alu_a   = pos_x;
		alu_b   = -rd_due_x;
		case (state_q)
			ts_sched_pkg::ST_IDLE: begin
				wr_en       = accept && func == ts_sched_pkg::FUNC_LOAD && load_ok;
				wr_addr     = ts_sched_pkg::IDX_W'(entry_index);
				wr_ent.live = ts_sched_pkg::is_live(stream_id, interval);
				wr_ent.sid  = stream_id;
				wr_ent.iv   = interval;
				wr_ent.due  = '0;
			end
			ts_sched_pkg::ST_SCAN: begin
				issue = (cnt_q != ts_sched_pkg::CNT_END);
			end
			ts_sched_pkg::ST_UPDATE: begin
				alu_a      = pick_due_x;
				alu_b      = {{(ts_sched_pkg::ACC_W-ts_sched_pkg::IV_W){1'b0}}, pick_q_ent.iv};
				wr_en      = found_q;
				wr_addr    = pick_q;
				wr_ent     = pick_q_ent;
				wr_ent.due = alu_sat;
				emit       = !closing_q;
			end
			ts_sched_pkg::ST_REBASE: begin
				issue      = (cnt_q != ts_sched_pkg::CNT_END);
				alu_a      = rd_due_x;
				alu_b      = -shift_x;
				wr_en      = live_s1;
				wr_ent.due = alu_sat;
				emit       = pass_done;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ts_sched_pkg::ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			valid_q   <= '0;
			spp_q     <= ts_sched_pkg::SPP_RESET;
			pos_q     <= '0;
			closing_q <= 1'b0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			done_q    <= (accept && func == ts_sched_pkg::FUNC_LOAD) || emit;
			if (cfg_we) begin
				spp_q <= cfg_wdata;
			end
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == ts_sched_pkg::ST_IDLE || state_q == ts_sched_pkg::ST_UPDATE) begin
				cnt_q <= '0;
			end
			if (state_q == ts_sched_pkg::ST_IDLE && wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (accept) begin
				closing_q <= (pos_q >= spp_q);
				found_q   <= 1'b0;
			end
			if (state_q == ts_sched_pkg::ST_SCAN && better) begin
				found_q <= 1'b1;
			end
			if (emit) begin
				pos_q  <= closing_q ? '0 : pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= rd_addr;
		valid_s1 <= valid_q[rd_addr];
		if (accept) begin
			best_q <= '0;
		end
		if (state_q == ts_sched_pkg::ST_SCAN && better) begin
			best_q     <= alu_sum;
			pick_q     <= idx_s1;
			pick_q_ent <= rd_ent;
		end
		if (accept && func == ts_sched_pkg::FUNC_LOAD) begin
			slot_kind_q     <= ts_sched_pkg::KIND_LOAD;
			chosen_index_q  <= entry_index;
			chosen_stream_q <= stream_id;
			period_end_q    <= 1'b0;
		end
		if (emit) begin
			slot_kind_q     <= found_q ? ts_sched_pkg::KIND_REAL : ts_sched_pkg::KIND_NULL;
			chosen_index_q  <= found_q ? 6'(pick_q) : '0;
			chosen_stream_q <= found_q ? pick_q_ent.sid : '0;
			period_end_q    <= closing_q;
		end
	end

	assign done          = done_q;
	assign slot_kind     = slot_kind_q;
	assign chosen_index  = chosen_index_q;
	assign chosen_stream = chosen_stream_q;
	assign period_end    = period_end_q;

endmodule
`default_nettype wire
